// ----- hw/rtl/kdhd_pkg.sv -----
// Shared types, codes and reset values for the keypad debounce and hold detector.
package kdhd_pkg;

   localparam int KEY_INDEX_WIDTH   = 3;
   localparam int THRESHOLD_WIDTH   = 8;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH    = 8;
   localparam int NUM_KEYS_DEFAULT  = 5;
   localparam int COUNT_WIDTH_DEFAULT = 8;

   localparam logic                       PRESSED_LEVEL_RESET    = 1'b1;
   localparam logic [THRESHOLD_WIDTH-1:0] DEBOUNCE_SAMPLES_RESET = 8'd3;
   localparam logic [THRESHOLD_WIDTH-1:0] HOLD_SAMPLES_RESET     = 8'd50;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PRESSED_LEVEL    = 2'd0,
      CSR_DEBOUNCE_SAMPLES = 2'd1,
      CSR_HOLD_SAMPLES     = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_RELEASE = 2'd2,
      EV_HOLD    = 2'd3
   } event_code_type;

   typedef enum logic [2:0] {
      KEY_RELEASED = 3'b001,
      KEY_PRESSED  = 3'b010,
      KEY_HOLDING  = 3'b100
   } key_state_type;

   typedef struct packed {
      logic [KEY_INDEX_WIDTH-1:0] key_index;
      logic                       pin_level;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] event_code;
      logic       bad_key;
   } rsp_payload_type;

endpackage

// ----- hw/rtl/keypad_debounce_hold_detect.sv -----
// Keypad debounce and hold detector: per-key state in a small synchronous memory.
//
// Accepts one key sample per clock and returns exactly one result per sample, in order.
// A result passes through the registered read of the key's entry in the state memory,
// then the update, which writes the entry back and loads the result register. A
// sample of the same key that directly follows takes the written-back entry by
// forwarding, so the rate stays at one request per cycle for any key order. The block
// stalls requests only while the result register is held by a stalled consumer and the
// update stage is full. After reset every key reads as released with zero counts; no
// clearing pass is needed. Configuration is written through the csr_ port; the user
// must write it only while the block is idle, as the block does not enforce this.
module keypad_debounce_hold_detect #(
   parameter int NUM_KEYS    = kdhd_pkg::NUM_KEYS_DEFAULT,
   parameter int COUNT_WIDTH = kdhd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  kdhd_pkg::req_payload_type                req_payload,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output kdhd_pkg::rsp_payload_type                rsp_payload,
   input  logic                                     csr_write_enable,
   input  logic [kdhd_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [kdhd_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);
   import kdhd_pkg::*;

   localparam int AddrWidth = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int CmpWidth  = (COUNT_WIDTH > THRESHOLD_WIDTH) ? COUNT_WIDTH
                                                               : THRESHOLD_WIDTH;

   typedef struct packed {
      key_state_type          state;
      logic [COUNT_WIDTH-1:0] on_count;
      logic [COUNT_WIDTH-1:0] off_count;
   } entry_type;

   // configuration
   logic                       pressed_level_ff;
   logic [THRESHOLD_WIDTH-1:0] debounce_samples_ff;
   logic [THRESHOLD_WIDTH-1:0] hold_samples_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_level_ff    <= PRESSED_LEVEL_RESET;
         debounce_samples_ff <= DEBOUNCE_SAMPLES_RESET;
         hold_samples_ff     <= HOLD_SAMPLES_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PRESSED_LEVEL:    pressed_level_ff    <= csr_wdata[0];
            CSR_DEBOUNCE_SAMPLES: debounce_samples_ff <= csr_wdata[THRESHOLD_WIDTH-1:0];
            CSR_HOLD_SAMPLES:     hold_samples_ff     <= csr_wdata[THRESHOLD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // handshake and pipeline control
   logic                 req_accept;
   logic                 s1_advance;
   logic                 s1_valid_ff;
   logic                 s1_bad_ff;
   logic                 s1_level_ff;
   logic [AddrWidth-1:0] s1_addr_ff;
   logic                 rsp_valid_ff;
   rsp_payload_type      rsp_payload_ff;
   logic                 req_bad;
   logic [AddrWidth-1:0] req_addr;

   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;
   assign req_bad    = {1'b0, req_payload.key_index} >= (KEY_INDEX_WIDTH + 1)'(NUM_KEYS);
   assign req_addr   = req_payload.key_index[AddrWidth-1:0];

   // state memory with write-back forwarding
   entry_type            mem [NUM_KEYS];
   logic [NUM_KEYS-1:0]  written_ff;
   entry_type            rd_entry_ff;
   logic                 rd_written_ff;
   logic                 fwd_ff;
   entry_type            fwd_entry_ff;
   logic                 wr_en;
   entry_type            wr_entry;
   entry_type            cur_entry;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[s1_addr_ff] <= wr_entry;
      end
      if (req_accept) begin
         rd_entry_ff <= mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
         fwd_ff        <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[s1_addr_ff] <= 1'b1;
         end
         if (req_accept) begin
            rd_written_ff <= written_ff[req_addr];
            fwd_ff        <= wr_en && (s1_addr_ff == req_addr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         fwd_entry_ff <= wr_entry;
         s1_bad_ff    <= req_bad;
         s1_level_ff  <= req_payload.pin_level;
         s1_addr_ff   <= req_addr;
      end
   end

   always_comb begin
      if (fwd_ff) begin
         cur_entry = fwd_entry_ff;
      end else if (rd_written_ff) begin
         cur_entry = rd_entry_ff;
      end else begin
         cur_entry = '{state: KEY_RELEASED, on_count: '0, off_count: '0};
      end
   end

   // key update
   logic                   down;
   logic [COUNT_WIDTH-1:0] on_inc;
   logic [COUNT_WIDTH-1:0] off_inc;
   event_code_type         event_code;

   assign down    = (s1_level_ff == pressed_level_ff);
   assign on_inc  = (&cur_entry.on_count) ? cur_entry.on_count
                                          : cur_entry.on_count + 1'b1;
   assign off_inc = (&cur_entry.off_count) ? cur_entry.off_count
                                           : cur_entry.off_count + 1'b1;

   always_comb begin
      wr_entry   = cur_entry;
      event_code = EV_NONE;
      case (cur_entry.state)
         KEY_PRESSED, KEY_HOLDING: begin
            if (down) begin
               wr_entry.off_count = '0;
               if (cur_entry.state == KEY_HOLDING) begin
                  event_code = EV_HOLD;
               end else if (CmpWidth'(on_inc) >= CmpWidth'(hold_samples_ff)) begin
                  wr_entry.on_count = '0;
                  wr_entry.state    = KEY_HOLDING;
                  event_code        = EV_HOLD;
               end else begin
                  wr_entry.on_count = on_inc;
               end
            end else if (CmpWidth'(off_inc) >= CmpWidth'(debounce_samples_ff)) begin
               wr_entry.off_count = '0;
               wr_entry.state     = KEY_RELEASED;
               event_code         = EV_RELEASE;
            end else begin
               wr_entry.off_count = off_inc;
            end
         end
         default: begin
            // released, or a code that should never be stored
            wr_entry.state = KEY_RELEASED;
            if (!down) begin
               wr_entry.on_count = '0;
            end else if (CmpWidth'(on_inc) >= CmpWidth'(debounce_samples_ff)) begin
               wr_entry.on_count = '0;
               wr_entry.state    = KEY_PRESSED;
               event_code        = EV_PRESS;
            end else begin
               wr_entry.on_count = on_inc;
            end
         end
      endcase
   end

   assign wr_en = s1_valid_ff && s1_advance && !s1_bad_ff;

   // update stage and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         rsp_payload_ff.event_code <= s1_bad_ff ? EV_NONE : event_code;
         rsp_payload_ff.bad_key    <= s1_bad_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- dv/keypad_debounce_hold_detect_test.sv -----
// Self-checking testbench for the keypad debounce and hold detector.
`timescale 1ns / 1ps

module keypad_debounce_hold_detect_test;
   import kdhd_pkg::*;

   localparam int KEY_COUNT   = NUM_KEYS_DEFAULT;
   localparam int COUNT_BITS  = COUNT_WIDTH_DEFAULT;

   // Tracks the debounced state of every key and the events it must report.
   class key_event_scoreboard;
      logic                       pressed_level;
      logic [THRESHOLD_WIDTH-1:0] debounce_samples;
      logic [THRESHOLD_WIDTH-1:0] hold_samples;
      key_state_type              key_state[KEY_COUNT];
      logic [COUNT_BITS-1:0]      on_count[KEY_COUNT];
      logic [COUNT_BITS-1:0]      off_count[KEY_COUNT];
      rsp_payload_type            expected_events[$];
      int                         errors;

      function new();
         pressed_level    = PRESSED_LEVEL_RESET;
         debounce_samples = DEBOUNCE_SAMPLES_RESET;
         hold_samples     = HOLD_SAMPLES_RESET;
         errors           = 0;
         for (int i = 0; i < KEY_COUNT; i++) begin
            key_state[i] = KEY_RELEASED;
            on_count[i]  = '0;
            off_count[i] = '0;
         end
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] value);
         case (idx)
            CSR_PRESSED_LEVEL:    pressed_level    = value[0];
            CSR_DEBOUNCE_SAMPLES: debounce_samples = value;
            CSR_HOLD_SAMPLES:     hold_samples     = value;
            default: ;
         endcase
      endfunction

      function logic [COUNT_BITS-1:0] count_up(logic [COUNT_BITS-1:0] value);
         return (value == '1) ? value : value + 1'b1;
      endfunction

      function void note_sample(req_payload_type sample);
         rsp_payload_type want;
         int              k;
         logic            down;
         want.event_code = EV_NONE;
         want.bad_key    = 1'b0;
         k               = int'(sample.key_index);
         if (k >= KEY_COUNT) begin
            want.bad_key = 1'b1;
         end else begin
            down = (sample.pin_level == pressed_level);
            if (key_state[k] == KEY_PRESSED || key_state[k] == KEY_HOLDING) begin
               if (down) begin
                  off_count[k] = '0;
                  if (key_state[k] == KEY_HOLDING) begin
                     want.event_code = EV_HOLD;
                  end else begin
                     on_count[k] = count_up(on_count[k]);
                     if (on_count[k] >= hold_samples) begin
                        on_count[k]     = '0;
                        key_state[k]    = KEY_HOLDING;
                        want.event_code = EV_HOLD;
                     end
                  end
               end else begin
                  off_count[k] = count_up(off_count[k]);
                  if (off_count[k] >= debounce_samples) begin
                     off_count[k]    = '0;
                     key_state[k]    = KEY_RELEASED;
                     want.event_code = EV_RELEASE;
                  end
               end
            end else if (down) begin
               on_count[k] = count_up(on_count[k]);
               if (on_count[k] >= debounce_samples) begin
                  on_count[k]     = '0;
                  key_state[k]    = KEY_PRESSED;
                  want.event_code = EV_PRESS;
               end
            end else begin
               on_count[k] = '0;
            end
         end
         expected_events.push_back(want);
      endfunction

      function void check_event(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_events.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual event_code %0d bad_key %0d",
                     $time, got.event_code, got.bad_key);
            return;
         end
         want = expected_events.pop_front();
         if (got.event_code !== want.event_code) begin
            errors++;
            $display("%0t: event_code mismatch: expected %0d actual %0d",
                     $time, want.event_code, got.event_code);
         end
         if (got.bad_key !== want.bad_key) begin
            errors++;
            $display("%0t: bad_key mismatch: expected %0d actual %0d",
                     $time, want.bad_key, got.bad_key);
         end
      endfunction

      function int pending();
         return expected_events.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   req_payload_type             req_payload;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   rsp_payload_type             rsp_payload;
   logic                        csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index;
   logic [CSR_DATA_WIDTH-1:0]   csr_wdata;

   key_event_scoreboard sb;
   logic                stall_enable = 1'b0;
   int                  stall_left   = 0;
   int                  free_left    = 0;
   int                  burst_left   = 0;
   int                  run_left[KEY_COUNT];
   logic                run_down[KEY_COUNT];

   keypad_debounce_hold_detect #(
      .NUM_KEYS    (KEY_COUNT),
      .COUNT_WIDTH (COUNT_BITS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   // Receiver: alternate free and stalled stretches of random length.
   always @(posedge clock) begin
      if (reset || !stall_enable) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else if (free_left > 0) begin
         rsp_stall <= 1'b0;
         free_left = free_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         free_left  = $urandom_range(0, 12);
         stall_left = $urandom_range(0, 6);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_sample(req_payload);
         if (rsp_valid && !rsp_stall)
            sb.check_event(rsp_payload);
      end
   end

   task automatic send_sample(int key, logic level);
      req_payload_type sample;
      sample.key_index = KEY_INDEX_WIDTH'(key);
      sample.pin_level = level;
      req_valid   <= 1'b1;
      req_payload <= sample;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_run(int key, logic level, int count);
      repeat (count) send_sample(key, level);
   endtask

   task automatic pause_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold the sender until every expected event has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      @(posedge clock);
      sb.write_register(idx, value);
   endtask

   task automatic load_settings(logic level, logic [7:0] debounce, logic [7:0] hold);
      logic [CSR_DATA_WIDTH-1:0] level_word;
      level_word    = CSR_DATA_WIDTH'($urandom_range(0, 255));
      level_word[0] = level;
      write_register(CSR_PRESSED_LEVEL, level_word);
      write_register(CSR_DEBOUNCE_SAMPLES, debounce);
      write_register(CSR_HOLD_SAMPLES, hold);
      csr_write_enable <= 1'b0;
   endtask

   // Random key activity: per-key runs of pressed and released samples near the
   // thresholds, with bounces and invalid keys mixed in.
   task automatic run_phase(logic level, logic [7:0] debounce, logic [7:0] hold,
                            int count, int key_span, bit stalls_on, bit gaps_on);
      int   sent;
      int   k;
      int   last_key;
      int   gap;
      int   db_len;
      int   hold_len;
      logic down;
      drain();
      load_settings(level, debounce, hold);
      stall_enable <= stalls_on;
      db_len   = (debounce == 0) ? 1 : debounce;
      hold_len = (hold == 0) ? 1 : hold;
      for (int i = 0; i < KEY_COUNT; i++) begin
         run_left[i] = 0;
         run_down[i] = 1'b1;
      end
      sent     = 0;
      last_key = 0;
      while (sent < count) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
               0:       gap = 0;
               3:       gap = $urandom_range(5, 25);
               default: gap = $urandom_range(1, 4);
            endcase
            if (gaps_on && gap > 0)
               pause_sender(gap);
         end
         burst_left--;
         if ($urandom_range(0, 9) == 0) begin
            send_sample($urandom_range(KEY_COUNT, 7), 1'($urandom_range(0, 1)));
         end else begin
            if ($urandom_range(0, 1) == 0 || last_key >= key_span)
               k = $urandom_range(0, key_span - 1);
            else
               k = last_key;
            if (run_left[k] == 0) begin
               run_down[k] = !run_down[k];
               if (run_down[k]) begin
                  case ($urandom_range(0, 3))
                     0:       run_left[k] = $urandom_range(1, db_len);
                     1:       run_left[k] = db_len + $urandom_range(0, hold_len - 1);
                     default: run_left[k] = db_len + hold_len + $urandom_range(0, 8);
                  endcase
               end else begin
                  if ($urandom_range(0, 3) == 0)
                     run_left[k] = $urandom_range(1, db_len);
                  else
                     run_left[k] = db_len + $urandom_range(0, 3);
               end
            end
            run_left[k]--;
            down = run_down[k];
            if ($urandom_range(0, 19) == 0)
               down = !down;
            send_sample(k, down ? level : !level);
            last_key = k;
         end
         sent++;
      end
   endtask

   initial begin
      sb = new();
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_payload      <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      repeat (8) @(posedge clock);
      reset        <= 1'b0;
      stall_enable <= 1'b1;

      // Reset settings: press, release, a broken press run, invalid keys.
      send_run(0, 1'b1, 3);
      send_run(0, 1'b0, 3);
      send_sample(4, 1'b1);
      send_sample(4, 1'b0);
      send_run(4, 1'b1, 3);
      send_sample(5, 1'b0);
      send_sample(7, 1'b1);

      // Active-low key; a release bounce while pressed keeps the press count.
      drain();
      load_settings(1'b0, 8'd2, 8'd3);
      send_run(1, 1'b0, 3);
      send_sample(1, 1'b1);
      send_run(1, 1'b0, 3);
      send_run(1, 1'b1, 2);

      // Zero thresholds: every counted sample meets its threshold.
      drain();
      load_settings(1'b1, 8'd0, 8'd0);
      send_run(3, 1'b1, 2);
      send_run(3, 1'b0, 2);

      run_phase(1'b1, 8'd1, 8'd1, 150, KEY_COUNT, 1'b0, 1'b0);
      run_phase(1'b0, 8'd2, 8'd4, 200, KEY_COUNT, 1'b1, 1'b1);
      run_phase(1'b1, 8'd3, 8'd50, 200, KEY_COUNT, 1'b1, 1'b1);
      run_phase(1'b0, 8'd255, 8'd255, 600, 1, 1'b1, 1'b1);
      run_phase(1'($urandom_range(0, 1)), 8'($urandom_range(1, 6)),
                8'($urandom_range(1, 12)), 150, KEY_COUNT, 1'b1, 1'b1);

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #4000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
